/* src/sgts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the sorted glyph table search unit.
// No dependencies; compiled first.
package sgts_pkg;

	// Field widths of the item and result transfers
	localparam int SLOT_W  = 8;
	localparam int CODE_W  = 16;
	localparam int ADV_W   = 4;
	localparam int COUNT_W = 9;
	localparam int ENTRY_W = CODE_W + ADV_W;

	// Default table depth
	localparam int TABLE_DEPTH_DEF = 256;

	// Item operation codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic write;     // store the accepted entry
		logic start;     // set up bounds and issue the first probe
		logic step;      // evaluate the returned probe, issue the next one
		logic out_load;  // move the search result into the output register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic count_zero;  // no entries to search
		logic probe_done;  // current probe ends the search
	} status_t;

endpackage

/* src/sgts_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: lookup/load items, results, count writes.
// Depends on sgts_pkg.
interface sgts_in_if;
	import sgts_pkg::*;
	logic              valid;
	logic              ready;
	logic              op;
	logic [SLOT_W-1:0] slot;
	logic [CODE_W-1:0] code_point;
	logic [ADV_W-1:0]  advance_width;
	modport source (output valid, op, slot, code_point, advance_width, input ready);
	modport sink (input valid, op, slot, code_point, advance_width, output ready);
endinterface

interface sgts_out_if;
	import sgts_pkg::*;
	logic              valid;
	logic              ready;
	logic              found;
	logic [SLOT_W-1:0] match_slot;
	logic [ADV_W-1:0]  glyph_width;
	modport source (output valid, found, match_slot, glyph_width, input ready);
	modport sink (input valid, found, match_slot, glyph_width, output ready);
endinterface

interface sgts_cfg_if;
	import sgts_pkg::*;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* src/sgts_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* src/sgts_dp.sv */
`timescale 1ns / 1ps
// Datapath: entry count register, search bounds, glyph table RAM, result registers.
// Depends on sgts_pkg and sgts_ram.
module sgts_dp #(
	parameter int TABLE_DEPTH = sgts_pkg::TABLE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sgts_pkg::cmd_t              cmd,
	output sgts_pkg::status_t           status,
	input  logic                        cfg_we,
	input  logic [sgts_pkg::COUNT_W-1:0] cfg_data,
	input  logic [sgts_pkg::SLOT_W-1:0]  in_slot,
	input  logic [sgts_pkg::CODE_W-1:0]  in_code,
	input  logic [sgts_pkg::ADV_W-1:0]   in_adv,
	output logic                        out_found,
	output logic [sgts_pkg::SLOT_W-1:0]  out_slot,
	output logic [sgts_pkg::ADV_W-1:0]   out_width
);
	import sgts_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [AW+SLOT_W-1:0] DepthSlot = (AW + SLOT_W)'(TABLE_DEPTH);
	localparam logic [CW+COUNT_W-1:0] DepthCnt = (CW + COUNT_W)'(TABLE_DEPTH);

	logic [COUNT_W-1:0]    entry_count_q;
	logic [CW+COUNT_W-1:0] cnt_wide;
	logic [CW-1:0]         count_eff;
	logic [CW-1:0]         first_span;
	logic [CW-1:0]         head_q;
	logic [CW-1:0]         hi_q;
	logic [AW-1:0]         mid_q;
	logic [CODE_W-1:0]     key_q;
	logic [CW-1:0]         mid_ext;
	logic [CW-1:0]         next_head;
	logic [CW-1:0]         next_hi;
	logic [CW-1:0]         next_span;
	logic [CW-1:0]         next_mid_c;
	logic [AW-1:0]         next_mid;
	logic [AW-1:0]         first_mid;
	logic [AW+SLOT_W-1:0]  slot_wide;
	logic [AW+SLOT_W-1:0]  mid_wide;
	logic                  wr_en;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [ENTRY_W-1:0]    rdata;
	logic [CODE_W-1:0]     probe_code;
	logic [ADV_W-1:0]      probe_adv;
	logic                  probe_eq;
	logic                  probe_gt;
	logic                  res_found_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic [ADV_W-1:0]      res_width_q;

	// Hold the entry count written over the configuration channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_data;
		end
	end

	// Clamp the count to the table depth
	assign cnt_wide  = {{CW{1'b0}}, entry_count_q};
	assign count_eff = (cnt_wide > DepthCnt) ? DepthCnt[CW-1:0] : cnt_wide[CW-1:0];
	assign status.count_zero = (count_eff == '0);

	// First probe: middle of [0, count)
	assign first_span = count_eff - CW'(1);
	assign first_mid  = AW'(first_span >> 1);

	// Compare the returned entry with the key
	assign probe_code = rdata[ENTRY_W-1:ADV_W];
	assign probe_adv  = rdata[ADV_W-1:0];
	assign probe_eq   = (probe_code == key_q);
	assign probe_gt   = (probe_code > key_q);

	// Narrow the bounds; the upper bound is exclusive so it never wraps below zero
	assign mid_ext    = CW'(mid_q);
	assign next_head  = (probe_eq || probe_gt) ? head_q : (mid_ext + CW'(1));
	assign next_hi    = probe_gt ? mid_ext : hi_q;
	assign next_span  = next_hi - next_head - CW'(1);
	assign next_mid_c = next_head + (next_span >> 1);
	assign next_mid   = next_mid_c[AW-1:0];
	assign status.probe_done = probe_eq || !(next_head < next_hi);

	// Drop loads to slots past the table end
	assign slot_wide = {{AW{1'b0}}, in_slot};
	assign wr_en     = cmd.write && (slot_wide < DepthSlot);

	// Issue the first probe at start, the next one while the search goes on
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = first_mid;
		if (cmd.start) begin
			rd_en   = !status.count_zero;
			rd_addr = first_mid;
		end else if (cmd.step) begin
			rd_en   = !status.probe_done;
			rd_addr = next_mid;
		end
	end

	sgts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(slot_wide[AW-1:0]),
		.wdata({in_code, in_adv}),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// Advance the bounds and capture a hit
	assign mid_wide = {{SLOT_W{1'b0}}, mid_q};
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			head_q      <= '0;
			hi_q        <= count_eff;
			mid_q       <= first_mid;
			key_q       <= in_code;
			res_found_q <= 1'b0;
			res_slot_q  <= '0;
			res_width_q <= '0;
		end else if (cmd.step) begin
			head_q <= next_head;
			hi_q   <= next_hi;
			mid_q  <= next_mid;
			if (probe_eq) begin
				res_found_q <= 1'b1;
				res_slot_q  <= mid_wide[SLOT_W-1:0];
				res_width_q <= probe_adv;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_found <= res_found_q;
			out_slot  <= res_slot_q;
			out_width <= res_width_q;
		end
	end
endmodule

/* src/sgts_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences item transfers, table probes and result transfers.
// Depends on sgts_pkg.
module sgts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output sgts_pkg::cmd_t     cmd,
	input  sgts_pkg::status_t  status
);
	import sgts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_PROBE = 3'b010,
		S_DONE  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_op == OP_LOOKUP) begin
						cmd.start = 1'b1;
						state_d   = status.count_zero ? S_DONE : S_PROBE;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			S_PROBE: begin
				cmd.step = 1'b1;
				if (status.probe_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result valid until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A non-empty lookup always enters the probe loop
	a_start_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && !status.count_zero) |=> (state_q == S_PROBE))
		else $error("lookup did not enter probe loop");

	// A finished search waits while the previous result is still pending
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> (state_q == S_DONE))
		else $error("result overwritten before transfer");

	// Loading the output register raises valid
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

	// No item is taken while a search runs
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !(cmd.start || cmd.write))
		else $error("item accepted during search");
endmodule

/* src/sorted_glyph_table_search_unit.sv */
`timescale 1ns / 1ps
// Top level of the sorted glyph table search unit: controller plus datapath.
// Depends on sgts_pkg, sgts_if, sgts_ctrl, sgts_dp, sgts_ram.
//
//  channel  dir  payload                                   transfer when
//  item     in   op, slot, code_point, advance_width       item.valid & item.ready
//  result   out  found, match_slot, glyph_width            result.valid & result.ready
//  cfg      in   data (entry_count)                        cfg.valid & cfg.ready
//
// A load is written to the table without leaving the idle state. A lookup takes no
// new item until its P probes are done and its result is loaded, P being at most
// floor(log2(count)) + 1, so 9 for 256 entries: one registered table read per probe.
// An empty table skips the probes. The result register lets the next item in
// while a result waits; a lookup then holds in its final state until it drains.
// Reset clears the entry count and the control state; the table is not cleared.
module sorted_glyph_table_search_unit #(
	parameter int TABLE_DEPTH = sgts_pkg::TABLE_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	sgts_in_if.sink    item,
	sgts_out_if.source result,
	sgts_cfg_if.sink   cfg
);
	import sgts_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Count writes are always taken
	assign cfg.ready = 1'b1;

	sgts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item.op),
		.in_ready (item.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.cmd      (cmd),
		.status   (status)
	);

	sgts_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg_we   (cfg.valid && cfg.ready),
		.cfg_data (cfg.data),
		.in_slot  (item.slot),
		.in_code  (item.code_point),
		.in_adv   (item.advance_width),
		.out_found(result.found),
		.out_slot (result.match_slot),
		.out_width(result.glyph_width)
	);
endmodule
